// ----- rtl/sor_linear_system_solver_macros.svh -----
// Assertion macros shared by the solver RTL.
// Needs nothing else; included by the files that carry concurrent checks.
`ifndef SOR_LINEAR_SYSTEM_SOLVER_MACROS_SVH
`define SOR_LINEAR_SYSTEM_SOLVER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SOR_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("solver check failed");

// Next-cycle implication, disabled while reset is high.
`define SOR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("solver check failed");

`endif

// ----- rtl/sor_pkg.sv -----
// Types and constants of the SOR linear system solver.
// No dependencies; imported by the solver top level.
package sor_pkg;

   localparam int MAX_UNKNOWNS = 16;
   localparam int FRAC_BITS    = 16;
   localparam int COLS         = MAX_UNKNOWNS + 1;
   localparam int STORE_DEPTH  = MAX_UNKNOWNS * COLS;
   localparam int SADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W        = $clog2(MAX_UNKNOWNS);
   localparam int NW           = $clog2(MAX_UNKNOWNS + 1);
   localparam int CW           = $clog2(COLS + 1);
   localparam int CSR_W        = 31;

   localparam logic [1:0] CSR_UNKNOWNS  = 2'd0;
   localparam logic [1:0] CSR_OMEGA     = 2'd1;
   localparam logic [1:0] CSR_TOLERANCE = 2'd2;
   localparam logic [1:0] CSR_ITER_LIM  = 2'd3;

   localparam logic [1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [1:0] STATUS_LIMIT     = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DIAG = 2'd2;

   typedef struct packed {
      logic [3:0]         row;
      logic [4:0]         column;
      logic signed [31:0] coefficient;
      logic               final_element;
   } req_word_type;

   typedef struct packed {
      logic [3:0]         unknown_index;
      logic signed [31:0] solution_value;
      logic [1:0]         status;
      logic [9:0]         sweeps_done;
      logic               last_result;
   } rsp_word_type;

endpackage

// ----- rtl/sor_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the coefficient store and the solution vector.
module sor_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sor_linear_system_solver.sv -----
// SOR linear system solver top level: load, row pivoting, sweeps, result output.
// Depends on sor_pkg, sor_ram and sor_linear_system_solver_macros.svh.
//
//   channel   direction  handshake            word
//   req       in         req_valid/req_stall  req_word_type, one matrix element
//   rsp       out        rsp_valid/rsp_stall  rsp_word_type, one solution entry
//   csr       in         csr_write            csr_index, csr_wdata
//
// Loading takes one word per cycle. The final element starts a solve that
// holds req stalled through pivoting and the sweeps; each sweep is paced by
// the coefficient RAM read port walking row by row and the 32-step divider
// after each row. Results then leave one word at a time, each through the
// read, load and wait states and held by any rsp stall. Reset is synchronous
// and needs no clearing pass; the solution vector carries a valid bit per entry.
`include "sor_linear_system_solver_macros.svh"
module sor_linear_system_solver
   import sor_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_word,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   localparam int NUMW = 64 + FRAC_BITS;
   localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_FIX_I, ST_FIX_IW, ST_FIX_JD, ST_FIX_JDW, ST_FIX_JCW,
      ST_CHK_RD, ST_CHK_W, ST_SW_START, ST_ROW, ST_DIV_INIT, ST_DIV_RUN,
      ST_MIX_Q, ST_MIX_P, ST_MIX_W, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
   } state_type;

   function automatic logic [SADDR_W-1:0] st_addr(logic [IDX_W-1:0] r, logic [CW-1:0] c);
      return SADDR_W'(r) * SADDR_W'(COLS) + SADDR_W'(c);
   endfunction

   state_type state_ff, state_in;
   logic [4:0]         unk_ff, unk_in;
   logic [16:0]        omega_ff, omega_in;
   logic [30:0]        tol_ff, tol_in;
   logic [9:0]         lim_ff, lim_in;
   logic [IDX_W-1:0]   perm_ff [MAX_UNKNOWNS];
   logic [IDX_W-1:0]   perm_in [MAX_UNKNOWNS];
   logic [MAX_UNKNOWNS-1:0] xv_ff, xv_in;
   logic [IDX_W-1:0]   pi_ff, pi_in, pj_ff, pj_in, i_ff, i_in, j_ff, j_in;
   logic               bad_ff, bad_in, conv_ff, conv_in;
   logic [9:0]         cnt_ff, cnt_in;
   logic [CW-1:0]      iss_ff, iss_in, s1j_ff, s1j_in;
   logic               s1v_ff, s1v_in, s2v_ff, s2v_in, xrdv_ff;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [31:0] b_ff, b_in, diag_ff, diag_in, xold_ff, xold_in, q_ff, q_in;
   logic [31:0]        div_p_ff, div_p_in, div_low_ff, div_low_in;
   logic [31:0]        div_q_ff, div_q_in, div_d_ff, div_d_in;
   logic               div_neg_ff, div_neg_in, div_ovf_ff, div_ovf_in;
   logic [4:0]         div_k_ff, div_k_in;
   logic signed [49:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic [NW-1:0]      n_act, nm1;
   logic [9:0]         lim_act;
   logic [IDX_W-1:0]   perm_sel, perm_val;
   logic               st_wr_en, x_wr_en;
   logic [SADDR_W-1:0] st_wr_addr, st_rd_addr;
   logic [IDX_W-1:0]   x_rd_addr;
   logic signed [31:0] st_rd, x_rd, x_wdata, xval;

   assign n_act = (unk_ff == 5'd0) ? NW'(1) :
                  (NW'(unk_ff) > NW'(MAX_UNKNOWNS)) ? NW'(MAX_UNKNOWNS) : NW'(unk_ff);
   assign nm1 = n_act - NW'(1);
   assign lim_act = (lim_ff == 10'd0) ? 10'd1 : lim_ff;
   assign perm_val = perm_ff[perm_sel];
   assign xval = xrdv_ff ? x_rd : 32'sd0;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign st_wr_en   = req_valid && !req_stall &&
                       (NW'(req_word.row) < n_act) && (NW'(req_word.column) <= n_act);
   assign st_wr_addr = st_addr(req_word.row, CW'(req_word.column));

   sor_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(st_wr_en), .wr_addr(st_wr_addr),
      .wr_data(req_word.coefficient), .rd_addr(st_rd_addr), .rd_data(st_rd)
   );

   sor_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_xvec (
      .clock(clock), .wr_en(x_wr_en), .wr_addr(i_ff),
      .wr_data(x_wdata), .rd_addr(x_rd_addr), .rd_data(x_rd)
   );

   always_comb begin
      logic               i_last, j_last;
      logic signed [63:0] r;
      logic [63:0]        absr;
      logic [NUMW-1:0]    num;
      logic [32:0]        trial;
      logic               ge;
      logic signed [17:0] omc;
      logic signed [50:0] mix;
      logic signed [34:0] mixs;
      logic signed [31:0] xnew;
      logic signed [32:0] diff;
      logic [32:0]        adiff;

      state_in = state_ff;   unk_in = unk_ff;     omega_in = omega_ff;
      tol_in = tol_ff;       lim_in = lim_ff;     perm_in = perm_ff;
      xv_in = xv_ff;         pi_in = pi_ff;       pj_in = pj_ff;
      i_in = i_ff;           j_in = j_ff;         bad_in = bad_ff;
      conv_in = conv_ff;     cnt_in = cnt_ff;     iss_in = iss_ff;
      s1j_in = iss_ff;       s1v_in = 1'b0;       s2v_in = 1'b0;
      prod_in = prod_ff;     acc_in = acc_ff;     b_in = b_ff;
      diag_in = diag_ff;     xold_in = xold_ff;   q_in = q_ff;
      div_p_in = div_p_ff;   div_low_in = div_low_ff;
      div_q_in = div_q_ff;   div_d_in = div_d_ff;
      div_neg_in = div_neg_ff; div_ovf_in = div_ovf_ff; div_k_in = div_k_ff;
      p1_in = p1_ff;         p2_in = p2_ff;       status_in = status_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      perm_sel = i_ff;
      st_rd_addr = st_addr(perm_val, CW'(i_ff));
      x_rd_addr = i_ff;
      x_wr_en = 1'b0;
      x_wdata = 32'sd0;

      i_last = (NW'(i_ff) == nm1);
      j_last = (NW'(j_ff) == nm1);
      r = 64'(b_ff) + acc_ff;
      absr = r[63] ? 64'(-r) : 64'(r);
      num = {absr, {FRAC_BITS{1'b0}}};
      trial = {div_p_ff, div_low_ff[31]};
      ge = (trial >= {1'b0, div_d_ff});
      omc = 18'sd65536 - $signed({1'b0, omega_ff});
      mix = 51'(p1_ff) + 51'(p2_ff);
      mixs = mix[50:16];
      xnew = (mixs > 35'(INT_MAX)) ? INT_MAX :
             (mixs < 35'(INT_MIN)) ? INT_MIN : mixs[31:0];
      diff = 33'(xnew) - 33'(xold_ff);
      adiff = diff[32] ? 33'(-diff) : 33'(diff);

      if (csr_write) begin
         unique case (csr_index)
            CSR_UNKNOWNS:  unk_in = csr_wdata[4:0];
            CSR_OMEGA:     omega_in = csr_wdata[16:0];
            CSR_TOLERANCE: tol_in = csr_wdata[30:0];
            CSR_ITER_LIM:  lim_in = csr_wdata[9:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_word.final_element) begin
               for (int k = 0; k < MAX_UNKNOWNS; k++) begin
                  perm_in[k] = IDX_W'(k);
               end
               xv_in = '0;
               cnt_in = 10'd0;
               bad_in = 1'b0;
               i_in = '0;
               state_in = ST_FIX_I;
            end
         end
         ST_FIX_I: begin
            pi_in = perm_val;
            state_in = ST_FIX_IW;
         end
         ST_FIX_IW: begin
            if (st_rd != 32'sd0) begin
               i_in = i_last ? '0 : i_ff + 1'b1;
               state_in = i_last ? ST_CHK_RD : ST_FIX_I;
            end else begin
               j_in = '0;
               state_in = ST_FIX_JD;
            end
         end
         ST_FIX_JD: begin
            perm_sel = j_ff;
            st_rd_addr = st_addr(perm_val, CW'(j_ff));
            pj_in = perm_val;
            state_in = ST_FIX_JDW;
         end
         ST_FIX_JDW, ST_FIX_JCW: begin
            st_rd_addr = st_addr(pj_ff, CW'(i_ff));
            if (st_rd != 32'sd0 && state_ff == ST_FIX_JDW) begin
               state_in = ST_FIX_JCW;
            end else if (st_rd != 32'sd0 || j_last) begin
               // A row with both entries nonzero swaps in, else row i stays.
               if (st_rd != 32'sd0) begin
                  perm_in[i_ff] = pj_ff;
                  perm_in[j_ff] = pi_ff;
               end
               i_in = i_last ? '0 : i_ff + 1'b1;
               state_in = i_last ? ST_CHK_RD : ST_FIX_I;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = ST_FIX_JD;
            end
         end
         ST_CHK_RD: begin
            state_in = ST_CHK_W;
         end
         ST_CHK_W: begin
            if (st_rd == 32'sd0) begin
               bad_in = 1'b1;
            end
            if (i_last) begin
               i_in = '0;
               if (bad_ff || st_rd == 32'sd0) begin
                  status_in = STATUS_ZERO_DIAG;
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_SW_START;
               end
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_CHK_RD;
            end
         end
         ST_SW_START: begin
            cnt_in = cnt_ff + 10'd1;
            conv_in = 1'b1;
            iss_in = '0;
            acc_in = 64'sd0;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            // Reads issue one column per cycle; each product is registered, then accumulated.
            st_rd_addr = st_addr(perm_val, iss_ff);
            x_rd_addr = iss_ff[IDX_W-1:0];
            if (CW'(iss_ff) <= CW'(n_act)) begin
               iss_in = iss_ff + 1'b1;
               s1v_in = 1'b1;
            end
            if (s1v_ff) begin
               if (s1j_ff == CW'(n_act)) begin
                  b_in = st_rd;
               end else if (s1j_ff == CW'(i_ff)) begin
                  diag_in = st_rd;
                  xold_in = xval;
               end else begin
                  prod_in = st_rd * xval;
                  s2v_in = 1'b1;
               end
            end
            if (s2v_ff) begin
               acc_in = acc_ff - (prod_ff >>> FRAC_BITS);
            end
            if (!(CW'(iss_ff) <= CW'(n_act)) && !s1v_ff && !s2v_ff) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            div_d_in = diag_ff[31] ? 32'(-diag_ff) : 32'(diag_ff);
            div_neg_in = r[63] ^ diag_ff[31];
            div_ovf_in = (num[NUMW-1:32] >= (NUMW-32)'(div_d_in));
            div_p_in = num[63:32];
            div_low_in = num[31:0];
            div_q_in = '0;
            div_k_in = '0;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            div_p_in = ge ? 32'(trial - {1'b0, div_d_ff}) : trial[31:0];
            div_q_in = {div_q_ff[30:0], ge};
            div_low_in = {div_low_ff[30:0], 1'b0};
            div_k_in = div_k_ff + 5'd1;
            if (div_k_ff == 5'd31) begin
               state_in = ST_MIX_Q;
            end
         end
         ST_MIX_Q: begin
            if (div_neg_ff) begin
               q_in = (div_ovf_ff || div_q_ff > 32'h8000_0000) ? INT_MIN :
                      $signed(32'(-div_q_ff));
            end else begin
               q_in = (div_ovf_ff || div_q_ff[31]) ? INT_MAX : $signed(div_q_ff);
            end
            state_in = ST_MIX_P;
         end
         ST_MIX_P: begin
            p1_in = $signed({1'b0, omega_ff}) * q_ff;
            p2_in = omc * xold_ff;
            state_in = ST_MIX_W;
         end
         ST_MIX_W: begin
            x_wdata = xnew;
            x_wr_en = 1'b1;
            xv_in[i_ff] = 1'b1;
            if (adiff >= {2'b00, tol_ff}) begin
               conv_in = 1'b0;
            end
            iss_in = '0;
            acc_in = 64'sd0;
            if (i_last) begin
               i_in = '0;
               if (conv_in || cnt_ff >= lim_act) begin
                  status_in = conv_in ? STATUS_CONVERGED : STATUS_LIMIT;
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_SW_START;
               end
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_ROW;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rsp_in.unknown_index = 4'(i_ff);
            rsp_in.solution_value = bad_ff ? 32'sd0 : xval;
            rsp_in.status = status_ff;
            rsp_in.sweeps_done = cnt_ff;
            rsp_in.last_result = i_last;
            rsp_valid_in = 1'b1;
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               i_in = i_ff + 1'b1;
               state_in = i_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         unk_ff <= 5'd16;
         omega_ff <= 17'd65536;
         tol_ff <= 31'd66;
         lim_ff <= 10'd1000;
         xv_ff <= '0;
         cnt_ff <= 10'd0;
         bad_ff <= 1'b0;
         s1v_ff <= 1'b0;
         s2v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unk_ff <= unk_in;
         omega_ff <= omega_in;
         tol_ff <= tol_in;
         lim_ff <= lim_in;
         xv_ff <= xv_in;
         cnt_ff <= cnt_in;
         bad_ff <= bad_in;
         s1v_ff <= s1v_in;
         s2v_ff <= s2v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      perm_ff <= perm_in;
      xrdv_ff <= xv_ff[x_rd_addr];
      pi_ff <= pi_in;           pj_ff <= pj_in;
      i_ff <= i_in;             j_ff <= j_in;
      conv_ff <= conv_in;       iss_ff <= iss_in;     s1j_ff <= s1j_in;
      prod_ff <= prod_in;       acc_ff <= acc_in;     b_ff <= b_in;
      diag_ff <= diag_in;       xold_ff <= xold_in;   q_ff <= q_in;
      div_p_ff <= div_p_in;     div_low_ff <= div_low_in;
      div_q_ff <= div_q_in;     div_d_ff <= div_d_in;
      div_neg_ff <= div_neg_in; div_ovf_ff <= div_ovf_in; div_k_ff <= div_k_in;
      p1_ff <= p1_in;           p2_ff <= p2_in;       status_ff <= status_in;
      rsp_ff <= rsp_in;
   end

   `SOR_ASSERT_NEXT(a_final_starts_solve, clock, reset, req_valid && !req_stall && req_word.final_element, state_ff == ST_FIX_I)
   `SOR_ASSERT_IMPL(a_div_remainder, clock, reset, state_ff == ST_DIV_RUN && !div_ovf_ff, div_p_ff < div_d_ff)
   `SOR_ASSERT_IMPL(a_rsp_from_emit, clock, reset, rsp_valid_ff, state_ff == ST_EMIT_WAIT)
   `SOR_ASSERT_IMPL(a_last_index, clock, reset, rsp_valid_ff && rsp_ff.last_result, NW'(rsp_ff.unknown_index) == nm1)

endmodule

// ----- dv/sor_linear_system_solver_tb.sv -----
// Self-checking testbench for the SOR linear system solver.
// Depends on sor_pkg and the sor_linear_system_solver RTL; predicts every solution word itself.
`timescale 1ns / 1ps
module sor_linear_system_solver_tb
   import sor_pkg::*;
;

   typedef enum int {FILL_DOMINANT, FILL_WILD, FILL_HOLES, FILL_SPARSE} fill_kind_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_word_type       req_word = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_word_type       rsp_word;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = CSR_UNKNOWNS;
   logic [CSR_W-1:0]   csr_wdata = '0;

   sor_linear_system_solver dut (.*);

   // Mirror of the configuration and the coefficient store.
   int unsigned   cfg_unknowns = 16;
   int unsigned   cfg_omega    = 65536;
   int unsigned   cfg_tol      = 66;
   int unsigned   cfg_limit    = 1000;
   longint        coef_mirror[MAX_UNKNOWNS][COLS];
   bit            coef_written[MAX_UNKNOWNS][COLS];

   rsp_word_type  solution_q[$];
   int            errors = 0;
   int            items_sent = 0;
   int            solves_run = 0;
   int            words_checked = 0;
   int            limit_hits = 0;
   int            zero_diag_hits = 0;
   bit            no_gaps = 1'b0;
   bit            hold_rsp = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(64'd20 * 64'd40_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int active_n();
      if (cfg_unknowns == 0) return 1;
      if (cfg_unknowns > MAX_UNKNOWNS) return MAX_UNKNOWNS;
      return cfg_unknowns;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit store_ready(int n);
      for (int i = 0; i < n; i++)
         for (int j = 0; j <= n; j++)
            if (!coef_written[i][j]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Pivot, sweep and queue the n solution words of one solve.
   task automatic solve_system();
      int           n;
      longint       wk[MAX_UNKNOWNS][COLS];
      longint       row_tmp[COLS];
      longint       cur[MAX_UNKNOWNS];
      longint       prev[MAX_UNKNOWNS];
      longint       r, a, ip, rem, q, mix, d;
      bit           bad;
      bit           done;
      int           sweeps;
      int           lim;
      logic [1:0]   st;
      rsp_word_type w;
      n = active_n();
      bad = 1'b0;
      done = 1'b0;
      sweeps = 0;
      for (int i = 0; i < n; i++) begin
         cur[i] = 0;
         prev[i] = 0;
         for (int j = 0; j <= n; j++) wk[i][j] = coef_mirror[i][j];
      end
      for (int i = 0; i < n; i++) begin
         if (wk[i][i] == 0) begin
            for (int j = 0; j < n; j++) begin
               if (wk[j][j] != 0 && wk[j][i] != 0) begin
                  for (int k = 0; k <= n; k++) begin
                     row_tmp[k] = wk[i][k];
                     wk[i][k] = wk[j][k];
                     wk[j][k] = row_tmp[k];
                  end
                  break;
               end
            end
         end
      end
      for (int i = 0; i < n; i++)
         if (wk[i][i] == 0) bad = 1'b1;
      if (bad) begin
         st = STATUS_ZERO_DIAG;
         zero_diag_hits++;
      end else begin
         lim = (cfg_limit == 0) ? 1 : cfg_limit;
         do begin
            sweeps++;
            for (int i = 0; i < n; i++) prev[i] = cur[i];
            for (int i = 0; i < n; i++) begin
               r = wk[i][n];
               a = wk[i][i];
               for (int j = 0; j < n; j++)
                  if (j != i) r -= (wk[i][j] * cur[j]) >>> FRAC_BITS;
               ip = r / a;
               rem = r % a;
               if (ip > 64'sd4294967296) ip = 64'sd4294967296;
               if (ip < -64'sd4294967296) ip = -64'sd4294967296;
               q = sat32(ip * 65536 + (rem * 65536) / a);
               mix = longint'(cfg_omega) * q + (64'sd65536 - longint'(cfg_omega)) * prev[i];
               cur[i] = sat32(mix >>> 16);
            end
            done = 1'b1;
            for (int i = 0; i < n; i++) begin
               d = prev[i] - cur[i];
               if (d < 0) d = -d;
               if (d >= longint'(cfg_tol)) done = 1'b0;
            end
         end while (!done && sweeps < lim);
         st = done ? STATUS_CONVERGED : STATUS_LIMIT;
         if (!done) limit_hits++;
      end
      for (int i = 0; i < n; i++) begin
         w.unknown_index  = i[3:0];
         w.solution_value = bad ? 32'sd0 : cur[i][31:0];
         w.status         = st;
         w.sweeps_done    = sweeps[9:0];
         w.last_result    = (i == n - 1);
         solution_q.push_back(w);
      end
      solves_run++;
   endtask

   task automatic write_csr(logic [1:0] idx, int unsigned val);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val[CSR_W-1:0];
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_UNKNOWNS:  cfg_unknowns = val & 32'h1F;
         CSR_OMEGA:     cfg_omega    = val & 32'h1FFFF;
         CSR_TOLERANCE: cfg_tol      = val & 32'h7FFFFFFF;
         CSR_ITER_LIM:  cfg_limit    = val & 32'h3FF;
         default: ;
      endcase
   endtask

   task automatic send_word(int row, int col, logic signed [31:0] coef, bit fin,
                            bit counted = 1'b1);
      int unsigned gap;
      int          n;
      gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_word.row = row[3:0];
      req_word.column = col[4:0];
      req_word.coefficient = coef;
      req_word.final_element = fin;
      do @(posedge clock); while (req_stall);
      n = active_n();
      if (row < n && col <= n) begin
         coef_mirror[row][col] = longint'(coef);
         coef_written[row][col] = 1'b1;
      end
      if (counted) items_sent++;
      if (fin) solve_system();
   endtask

   // Lower valid, drain every expected word, then let the solver settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      wait (solution_q.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic signed [31:0] fill_value(fill_kind_type kind, int i, int j, int n);
      logic signed [31:0] v;
      case (kind)
         FILL_DOMINANT, FILL_HOLES: begin
            if (j == n) v = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            else if (i == j) begin
               v = (n * 4 + $urandom_range(1, 255)) << 16;
               if ($urandom_range(0, 1)) v = -v;
               if (kind == FILL_HOLES && $urandom_range(0, 2) == 0) v = 0;
            end else v = $signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000;
         end
         FILL_WILD: v = $urandom;
         default: v = ($urandom_range(0, 3) == 0) ? 0 : ($signed($urandom_range(0, 8)) - 4) << 16;
      endcase
      return v;
   endfunction

   // Load the whole augmented matrix in shuffled order, with ignored words mixed in when noise is set.
   task automatic load_matrix(int n, fill_kind_type kind, bit noise = 1'b1);
      int cells[$];
      int r, c;
      for (int i = 0; i < n * (n + 1); i++) cells.push_back(i);
      cells.shuffle();
      for (int i = 0; i < cells.size(); i++) begin
         r = cells[i] / (n + 1);
         c = cells[i] % (n + 1);
         if (noise && $urandom_range(0, 9) == 0) begin
            if (n < MAX_UNKNOWNS && $urandom_range(0, 1))
               send_word($urandom_range(n, 15), $urandom_range(0, 31), $urandom, 1'b0, 1'b0);
            else
               send_word($urandom_range(0, 15), $urandom_range(n + 1, 31), $urandom, 1'b0, 1'b0);
         end
         send_word(r, c, fill_value(kind, r, c, n), i == cells.size() - 1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (solution_q.size() == 0) begin
            $error("unexpected solution word %p", rsp_word);
            errors++;
         end else begin
            rsp_word_type e;
            e = solution_q.pop_front();
            if (rsp_word.unknown_index !== e.unknown_index) begin
               $error("unknown_index expected %0d actual %0d", e.unknown_index,
                      rsp_word.unknown_index);
               errors++;
            end
            if (rsp_word.solution_value !== e.solution_value) begin
               $error("solution_value expected %0d actual %0d", e.solution_value,
                      rsp_word.solution_value);
               errors++;
            end
            if (rsp_word.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_word.status);
               errors++;
            end
            if (rsp_word.sweeps_done !== e.sweeps_done) begin
               $error("sweeps_done expected %0d actual %0d", e.sweeps_done,
                      rsp_word.sweeps_done);
               errors++;
            end
            if (rsp_word.last_result !== e.last_result) begin
               $error("last_result expected %0d actual %0d", e.last_result,
                      rsp_word.last_result);
               errors++;
            end
         end
      end
   end

   // Result-side back-pressure, including one long hold-off on request.
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_left = 3000;
            hold_rsp = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   task automatic test_single_unknown();
      wait_idle();
      write_csr(CSR_UNKNOWNS, 1);
      write_csr(CSR_OMEGA, 65536);
      write_csr(CSR_TOLERANCE, 66);
      write_csr(CSR_ITER_LIM, 50);
      send_word(0, 0, 32'sh0002_0000, 1'b0);
      send_word(0, 1, 32'sh0006_0000, 1'b1);
      send_word(0, 0, 32'sd0, 1'b1);
      send_word(0, 0, -32'sh0001_0000, 1'b0);
      send_word(0, 1, 32'sh8000_0000, 1'b1);
      send_word(0, 1, 32'sh7FFF_FFFF, 1'b1);
   endtask

   task automatic test_pivoting();
      wait_idle();
      write_csr(CSR_UNKNOWNS, 2);
      // Zero on the first diagonal that a later row can repair.
      send_word(0, 0, 32'sd0, 1'b0);
      send_word(0, 1, 32'sh0001_0000, 1'b0);
      send_word(0, 2, 32'sh0003_0000, 1'b0);
      send_word(1, 0, 32'sh0002_0000, 1'b0);
      send_word(1, 1, 32'sh0001_0000, 1'b0);
      send_word(1, 2, 32'sh0004_0000, 1'b1);
      // A zero column leaves the diagonal zero whatever is swapped.
      send_word(1, 0, 32'sd0, 1'b0);
      send_word(0, 1, 32'sd0, 1'b0);
      send_word(1, 1, 32'sh0005_0000, 1'b1);
   endtask

   task automatic test_register_extremes();
      wait_idle();
      write_csr(CSR_OMEGA, 0);
      send_word(0, 0, 32'sh0004_0000, 1'b0);
      send_word(0, 1, 32'sh0001_0000, 1'b1);
      wait_idle();
      write_csr(CSR_OMEGA, 131071);
      write_csr(CSR_TOLERANCE, 0);
      write_csr(CSR_ITER_LIM, 5);
      send_word(1, 0, 32'sh0001_0000, 1'b1);
      wait_idle();
      write_csr(CSR_OMEGA, 65536);
      write_csr(CSR_TOLERANCE, 32'h7FFF_FFFF);
      write_csr(CSR_ITER_LIM, 1);
      send_word(1, 2, -32'sh0003_0000, 1'b1);
      wait_idle();
      write_csr(CSR_TOLERANCE, 66);
      write_csr(CSR_ITER_LIM, 0);
      send_word(0, 2, 32'sh0002_8000, 1'b1);
   endtask

   task automatic test_full_size();
      wait_idle();
      write_csr(CSR_UNKNOWNS, 16);
      write_csr(CSR_ITER_LIM, 1023);
      write_csr(CSR_TOLERANCE, 66);
      load_matrix(16, FILL_DOMINANT, 1'b1);
      wait_idle();
      // Out-of-range counts act as the largest and the smallest system.
      write_csr(CSR_UNKNOWNS, 31);
      write_csr(CSR_ITER_LIM, 6);
      send_word(3, 16, 32'sh0010_0000, 1'b1);
      wait_idle();
      write_csr(CSR_UNKNOWNS, 0);
      send_word(0, 1, -32'sh0000_4000, 1'b1);
   endtask

   task automatic test_backpressure();
      wait_idle();
      write_csr(CSR_UNKNOWNS, 2);
      write_csr(CSR_ITER_LIM, 20);
      no_gaps = 1'b1;
      hold_rsp = 1'b1;
      load_matrix(2, FILL_DOMINANT, 1'b0);
      load_matrix(2, FILL_DOMINANT, 1'b0);
      load_matrix(2, FILL_SPARSE, 1'b0);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_systems();
      int         n;
      fill_kind_type kind;
      int unsigned tol;
      int unsigned om;
      int unsigned lim;
      int         sel;
      while (items_sent < 430) begin
         wait_idle();
         no_gaps = ($urandom_range(0, 7) == 0);
         sel = $urandom_range(0, 9);
         n = (sel < 7) ? $urandom_range(1, 4) : $urandom_range(5, 8);
         kind = fill_kind_type'($urandom_range(0, 9) < 6 ? FILL_DOMINANT : $urandom_range(1, 3));
         case ($urandom_range(0, 3))
            0: om = 0;
            1: om = 131071;
            2: om = 65536;
            default: om = $urandom_range(0, 131071);
         endcase
         case ($urandom_range(0, 3))
            0: tol = 0;
            1: tol = 66;
            2: tol = $urandom_range(0, 32'h000F_FFFF);
            default: tol = $urandom_range(0, 32'h7FFF_FFFF);
         endcase
         if (kind == FILL_DOMINANT && om == 65536 && tol >= 66 && $urandom_range(0, 2) == 0)
            lim = 1023;
         else
            lim = $urandom_range(1, 24);
         write_csr(CSR_UNKNOWNS, (n == 1 && $urandom_range(0, 1)) ? 0 : n);
         write_csr(CSR_OMEGA, om);
         write_csr(CSR_TOLERANCE, tol);
         write_csr(CSR_ITER_LIM, lim);
         if (store_ready(n) && $urandom_range(0, 3) == 0) begin
            // Touch a few entries of the stored system and solve again.
            repeat ($urandom_range(0, 3))
               send_word($urandom_range(0, n - 1), $urandom_range(0, n), $urandom, 1'b0);
            if ($urandom_range(0, 1))
               send_word($urandom_range(0, 15), $urandom_range(n + 1, 31), $urandom, 1'b1);
            else
               send_word($urandom_range(0, n - 1), n, fill_value(kind, 0, n, n), 1'b1);
         end else begin
            load_matrix(n, kind);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_single_unknown();
      test_pivoting();
      test_register_extremes();
      test_full_size();
      test_backpressure();
      test_random_systems();
      wait_idle();
      repeat (200) @(posedge clock);
      if (solution_q.size() != 0) begin
         $error("%0d solution words never arrived", solution_q.size());
         errors++;
      end
      $display("Ran %0d solves from %0d words; %0d solution words checked.",
               solves_run, items_sent, words_checked);
      $display("Solves stopped by the sweep limit: %0d, by a zero diagonal: %0d.",
               limit_hits, zero_diag_hits);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sor_linear_system_solver.f -----
+incdir+rtl
rtl/sor_pkg.sv
rtl/sor_ram.sv
rtl/sor_linear_system_solver.sv
dv/sor_linear_system_solver_tb.sv
